FILE: hw/rtl/rltc_pkg.sv
// Shared types and codes for the redo log transaction controller.
package rltc_pkg;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COPY_LOG,
    ST_HDR_COMMIT,
    ST_INSTALL,
    ST_HDR_CLEAR
  } state_t;

  // Command codes carried on the input word.
  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_END   = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // Action codes of a result word.
  localparam logic [1:0] ACT_STATUS = 2'd0;
  localparam logic [1:0] ACT_COPY   = 2'd1;
  localparam logic [1:0] ACT_HEADER = 2'd2;

  // Status codes of a result word.
  localparam logic [3:0] STS_GRANTED   = 4'd0;
  localparam logic [3:0] STS_WAIT      = 4'd1;
  localparam logic [3:0] STS_APPENDED  = 4'd2;
  localparam logic [3:0] STS_ABSORBED  = 4'd3;
  localparam logic [3:0] STS_ENDED     = 4'd4;
  localparam logic [3:0] STS_COMMITTED = 4'd5;
  localparam logic [3:0] STS_FULL      = 4'd6;
  localparam logic [3:0] STS_OUTSIDE   = 4'd7;
  localparam logic [3:0] STS_UNMATCHED = 4'd8;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LOG_START = 2'd0;
  localparam logic [1:0] CFG_LOG_AREA  = 2'd1;
  localparam logic [1:0] CFG_BLK_PER_OP = 2'd2;

  // Fixed field widths.
  localparam int BLK_W    = 32;
  localparam int AREA_W   = 16;
  localparam int BPO_W    = 5;
  localparam int OPS_W    = 6;
  localparam int HCOUNT_W = 5;

  localparam logic [OPS_W-1:0] MAX_OUTSTANDING = 6'd63;

endpackage

FILE: hw/rtl/redo_log_transaction_controller_unit.sv
// Redo log transaction controller: begin/end bracketing, block table and commit sequencer.
// Begin, end and rejected writes register their result word in the cycle after acceptance
// (an end that starts a commit gives copy words instead); a log write searches the table one
// entry per cycle while the output is free. One input word is in flight; the next is taken
// only once the controller is back in idle and the output register is free.
// Reset (rst_n low, synchronous) clears counts, state, output valid and loads the defaults.
module redo_log_transaction_controller_unit #(
  parameter int LOG_ENTRIES = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] block_number
  input  logic [1:0]  in_tuser,   // [1:0] command
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [31:0] source_block, [63:32] dest_block,
                                  // [68:64] header_count, [72:69] status, rest zero
  output logic [1:0]  out_tuser,  // [1:0] action
  output logic        out_tlast,  // last
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Table address width and count width follow from the table depth.
  localparam int AW = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;
  localparam int CW = $clog2(LOG_ENTRIES + 1);
  localparam logic [CW-1:0] ENTRIES_C = CW'(LOG_ENTRIES);

  // Configuration registers.
  logic [rltc_pkg::BLK_W-1:0]  log_start_r;
  logic [rltc_pkg::AREA_W-1:0] log_area_r;
  logic [rltc_pkg::BPO_W-1:0]  bpo_r;

  // Control state.
  rltc_pkg::state_t            state_r, state_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [rltc_pkg::OPS_W-1:0]  ops_r, ops_nxt;
  logic [CW-1:0]               idx_r, idx_nxt;
  logic                        out_valid_r, out_valid_nxt;

  // Block number of a log write under search.
  logic [rltc_pkg::BLK_W-1:0]  blk_r, blk_nxt;

  // Output payload registers.
  logic [1:0]                  out_action_r;
  logic [rltc_pkg::BLK_W-1:0]  out_src_r;
  logic [rltc_pkg::BLK_W-1:0]  out_dst_r;
  logic [rltc_pkg::HCOUNT_W-1:0] out_hcnt_r;
  logic [3:0]                  out_status_r;
  logic                        out_last_r;

  // Block table: one write port, one registered read port.
  logic [rltc_pkg::BLK_W-1:0]  mem [LOG_ENTRIES];
  logic [rltc_pkg::BLK_W-1:0]  rd_data_r;
  logic [AW-1:0]               rd_addr;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [rltc_pkg::BLK_W-1:0]  mem_wdata;

  // Result word being produced this cycle.
  logic                        emit;
  logic [1:0]                  e_action;
  logic [rltc_pkg::BLK_W-1:0]  e_src;
  logic [rltc_pkg::BLK_W-1:0]  e_dst;
  logic [rltc_pkg::HCOUNT_W-1:0] e_hcnt;
  logic [3:0]                  e_status;
  logic                        e_last;

  logic                        out_free;
  logic                        in_acc;
  logic                        table_full;
  logic                        last_entry;
  logic [12:0]                 need;
  logic [rltc_pkg::BLK_W-1:0]  slot_blk;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == rltc_pkg::ST_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;

  // Room check for a log write: table depth and the log area, header included.
  assign table_full = (count_r >= ENTRIES_C) ||
                      ((17'(count_r) + 17'd1) >= {1'b0, log_area_r});
  // Reservation for a begin: logged blocks plus one share per outstanding operation.
  assign need = 13'(count_r) + 13'(7'({1'b0, ops_r} + 7'd1)) * 13'(bpo_r);
  assign last_entry = (({1'b0, idx_r} + 1'b1) == {1'b0, count_r});
  // Log slot of the entry currently read.
  assign slot_blk = log_start_r + 32'd1 + 32'(idx_r);

  // The read address follows the next index, so rd_data_r always holds the table
  // word for idx_r, also while the output stalls.
  assign rd_addr = idx_nxt[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ops_nxt   = ops_r;
    idx_nxt   = idx_r;
    blk_nxt   = blk_r;
    mem_we    = 1'b0;
    mem_waddr = count_r[AW-1:0];
    mem_wdata = blk_r;
    emit      = 1'b0;
    e_action  = rltc_pkg::ACT_STATUS;
    e_src     = '0;
    e_dst     = '0;
    e_hcnt    = '0;
    e_status  = rltc_pkg::STS_GRANTED;
    e_last    = 1'b1;
    case (state_r)
      rltc_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            rltc_pkg::CMD_BEGIN: begin
              emit = 1'b1;
              if (ops_r == rltc_pkg::MAX_OUTSTANDING || need > 13'(LOG_ENTRIES)) begin
                e_status = rltc_pkg::STS_WAIT;
              end else begin
                e_status = rltc_pkg::STS_GRANTED;
                ops_nxt  = ops_r + 1'b1;
              end
            end
            rltc_pkg::CMD_END: begin
              if (ops_r == '0) begin
                emit     = 1'b1;
                e_status = rltc_pkg::STS_UNMATCHED;
              end else begin
                ops_nxt = ops_r - 1'b1;
                if (ops_r != 6'd1 || count_r == '0) begin
                  emit     = 1'b1;
                  e_status = rltc_pkg::STS_ENDED;
                end else begin
                  idx_nxt   = '0;
                  state_nxt = rltc_pkg::ST_COPY_LOG;
                end
              end
            end
            rltc_pkg::CMD_WRITE: begin
              if (table_full) begin
                emit     = 1'b1;
                e_status = rltc_pkg::STS_FULL;
              end else if (ops_r == '0) begin
                emit     = 1'b1;
                e_status = rltc_pkg::STS_OUTSIDE;
              end else if (count_r == '0) begin
                // Empty table: nothing to absorb, append at once.
                mem_we    = 1'b1;
                mem_wdata = in_tdata;
                count_nxt = count_r + 1'b1;
                emit      = 1'b1;
                e_status  = rltc_pkg::STS_APPENDED;
              end else begin
                blk_nxt   = in_tdata;
                idx_nxt   = '0;
                state_nxt = rltc_pkg::ST_SEARCH;
              end
            end
            default: begin
              // Unknown command: dropped without a result.
            end
          endcase
        end
      end
      rltc_pkg::ST_SEARCH: begin
        if (out_free) begin
          if (rd_data_r == blk_r) begin
            emit      = 1'b1;
            e_status  = rltc_pkg::STS_ABSORBED;
            state_nxt = rltc_pkg::ST_IDLE;
          end else if (last_entry) begin
            mem_we    = 1'b1;
            count_nxt = count_r + 1'b1;
            emit      = 1'b1;
            e_status  = rltc_pkg::STS_APPENDED;
            state_nxt = rltc_pkg::ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      rltc_pkg::ST_COPY_LOG: begin
        if (out_free) begin
          emit     = 1'b1;
          e_action = rltc_pkg::ACT_COPY;
          e_src    = rd_data_r;
          e_dst    = slot_blk;
          e_status = rltc_pkg::STS_COMMITTED;
          e_last   = 1'b0;
          if (last_entry) begin
            state_nxt = rltc_pkg::ST_HDR_COMMIT;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      rltc_pkg::ST_HDR_COMMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          e_action  = rltc_pkg::ACT_HEADER;
          e_dst     = log_start_r;
          e_hcnt    = rltc_pkg::HCOUNT_W'(count_r);
          e_status  = rltc_pkg::STS_COMMITTED;
          e_last    = 1'b0;
          idx_nxt   = '0;
          state_nxt = rltc_pkg::ST_INSTALL;
        end
      end
      rltc_pkg::ST_INSTALL: begin
        if (out_free) begin
          emit     = 1'b1;
          e_action = rltc_pkg::ACT_COPY;
          e_src    = slot_blk;
          e_dst    = rd_data_r;
          e_status = rltc_pkg::STS_COMMITTED;
          e_last   = 1'b0;
          if (last_entry) begin
            state_nxt = rltc_pkg::ST_HDR_CLEAR;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      rltc_pkg::ST_HDR_CLEAR: begin
        if (out_free) begin
          emit      = 1'b1;
          e_action  = rltc_pkg::ACT_HEADER;
          e_dst     = log_start_r;
          e_status  = rltc_pkg::STS_COMMITTED;
          e_last    = 1'b1;
          count_nxt = '0;
          state_nxt = rltc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rltc_pkg::ST_IDLE;
      end
    endcase
    out_valid_nxt = out_free ? emit : out_valid_r;
  end

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rltc_pkg::ST_IDLE;
      count_r     <= '0;
      ops_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      log_start_r <= 32'd2;
      log_area_r  <= 16'd30;
      bpo_r       <= 5'd10;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ops_r       <= ops_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rltc_pkg::CFG_LOG_START:  log_start_r <= cfg_data;
          rltc_pkg::CFG_LOG_AREA:   log_area_r  <= cfg_data[rltc_pkg::AREA_W-1:0];
          rltc_pkg::CFG_BLK_PER_OP: bpo_r       <= cfg_data[rltc_pkg::BPO_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    if (out_free && emit) begin
      out_action_r <= e_action;
      out_src_r    <= e_src;
      out_dst_r    <= e_dst;
      out_hcnt_r   <= e_hcnt;
      out_status_r <= e_status;
      out_last_r   <= e_last;
    end
  end

  // Block table.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_status_r, out_hcnt_r, out_dst_r, out_src_r};
  assign out_tuser  = out_action_r;
  assign out_tlast  = out_last_r;

endmodule
